/* rtl/work_stealing_deque_pool_macros.svh */
// assertion macros for the work stealing deque pool
`ifndef WORK_STEALING_DEQUE_POOL_MACROS_SVH
`define WORK_STEALING_DEQUE_POOL_MACROS_SVH

`ifndef SYNTH
// same cycle implication
`define WSDP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("deque pool check failed");
// next cycle implication
`define WSDP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("deque pool check failed");
`else
`define WSDP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define WSDP_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* rtl/wsdp_pkg.sv */
// shared constants and types of the work stealing deque pool
package wsdp_pkg;

    localparam int FUNC_W      = 2;
    localparam int IDX_W       = 3;
    localparam int HANDLE_W    = 16;
    localparam int PICK_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int FROM_W      = 3;
    localparam int WCNT_W      = 4;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 3;

    localparam logic [FUNC_W-1:0] FN_SUBMIT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_FETCH  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_SCAN   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_PUSHED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TAKEN   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE    = 2'd3;

    typedef struct packed {
        logic              start;
        logic [PICK_W-1:0] dividend;
        logic [WCNT_W-1:0] divisor;
    } t_mod_req;

endpackage

/* rtl/wsdp_ram.sv */
// generic single write port ram with registered read
module wsdp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/wsdp_mod.sv */
// bit serial remainder of the random pick by a divisor derived from the worker count
module wsdp_mod
    import wsdp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mod_req          i_req,
    output logic              o_valid,
    output logic [WCNT_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(PICK_W);

    logic              r_run, n_run;
    logic              r_valid, n_valid;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [PICK_W-1:0] r_q, n_q;
    logic [WCNT_W-1:0] r_rem, n_rem;
    logic [WCNT_W-1:0] r_div, n_div;
    logic [WCNT_W:0]   trial;

    always_comb begin
        n_run   = r_run;
        n_valid = r_valid;
        n_cnt   = r_cnt;
        n_q     = r_q;
        n_rem   = r_rem;
        n_div   = r_div;
        trial   = {r_rem, r_q[PICK_W-1]};
        if (trial >= {1'b0, r_div}) begin
            trial = trial - {1'b0, r_div};
        end
        if (i_req.start) begin
            n_run   = 1'b1;
            n_valid = 1'b0;
            n_cnt   = CNT_W'(PICK_W - 1);
            n_q     = i_req.dividend;
            n_rem   = '0;
            n_div   = i_req.divisor;
        end else if (r_run) begin
            n_rem = trial[WCNT_W-1:0];
            n_q   = {r_q[PICK_W-2:0], 1'b0};
            if (r_cnt == '0) begin
                n_run   = 1'b0;
                n_valid = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_run   <= n_run;
            r_valid <= n_valid;
        end
        r_cnt <= n_cnt;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;

endmodule

/* rtl/work_stealing_deque_pool.sv */
// top level of the work stealing deque pool: control, pointer and task memories
// Pool of bounded ring deques of task handles, one per worker. A submit word pushes
// at the bottom of one deque, a fetch pops its own deque at the bottom and otherwise
// steals from the top of a victim picked from the random value, a scan steals from
// the first non-empty deque from a random start. One word is in work at a time;
// a new word is taken while the last result still waits at the output. Handling
// uses the registered read of the pointer memory and then of the task memory, the
// bit-serial remainder unit (started at accept) and, for a scan, a visit of one
// deque per cycle. No clearing pass after reset: per-deque valid bits make
// untouched pointer entries read as empty.
module work_stealing_deque_pool
    import wsdp_pkg::*;
#(
    parameter int DEQUE_CAPACITY = 64,
    parameter int MAX_WORKERS    = 8,
    parameter int TASK_BITS      = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration: active_workers
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [WCNT_W-1:0]      i_cfg_data,
    // input words
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // deque_index[2:0], task_handle[18:3], random_pick[26:19], zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // func[1:0]
    input  logic [FUNC_W-1:0]      s_axis_tuser,
    // result words
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // task_out[15:0], from_deque[18:16], zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // status[1:0], was_stolen[2]
    output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    `include "work_stealing_deque_pool_macros.svh"

    localparam int IW    = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int PW    = $clog2(DEQUE_CAPACITY);
    localparam int CW    = $clog2(DEQUE_CAPACITY + 1);
    localparam int SW    = CW + 1;
    localparam int PTR_W = PW + CW;
    localparam int TDEP  = MAX_WORKERS * DEQUE_CAPACITY;
    localparam int AW    = (TDEP > 1) ? $clog2(TDEP) : 1;
    localparam logic [AW-1:0] CAP_A = AW'(DEQUE_CAPACITY);
    localparam logic [SW-1:0] CAP_S = SW'(DEQUE_CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(DEQUE_CAPACITY);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PRD  = 4'd1;
    localparam logic [3:0] S_MODV = 4'd2;
    localparam logic [3:0] S_MODW = 4'd3;
    localparam logic [3:0] S_SCAN = 4'd4;
    localparam logic [3:0] S_STL  = 4'd5;
    localparam logic [3:0] S_TRD  = 4'd6;
    localparam logic [3:0] S_OUT  = 4'd7;

    logic [3:0]             r_state, n_state;
    logic [WCNT_W-1:0]      r_aw;
    logic [FUNC_W-1:0]      r_func, n_func;
    logic [IW-1:0]          r_own, n_own;
    logic [IW-1:0]          r_d, n_d;
    logic [WCNT_W-1:0]      r_i, n_i;
    logic [TASK_BITS-1:0]   r_handle, n_handle;
    logic                   r_stolen, n_stolen;
    logic [STATUS_W-1:0]    r_res_status, n_res_status;
    logic [HANDLE_W-1:0]    r_res_task, n_res_task;
    logic [FROM_W-1:0]      r_res_from, n_res_from;
    logic                   r_res_stolen, n_res_stolen;
    logic                   r_ovalid, n_ovalid;
    logic [OUT_TDATA_W-1:0] r_otdata, n_otdata;
    logic [OUT_TUSER_W-1:0] r_otuser, n_otuser;
    logic [MAX_WORKERS-1:0] r_pvalid, n_pvalid;
    logic [MAX_WORKERS-1:0] r_nonempty, n_nonempty;
    logic                   r_prd_valid, n_prd_valid;

    logic [IDX_W-1:0]       in_idx;
    logic [HANDLE_W-1:0]    in_handle;
    logic [PICK_W-1:0]      in_pick;
    logic                   in_accept;
    logic [WCNT_W-1:0]      eff_workers;
    logic                   idx_ok;

    logic                   ptr_re, ptr_we;
    logic [IW-1:0]          ptr_raddr;
    logic [PTR_W-1:0]       ptr_wdata, ptr_rdata;
    logic [PW-1:0]          ptr_top;
    logic [CW-1:0]          ptr_cnt;
    logic                   task_re, task_we;
    logic [AW-1:0]          task_addr;
    logic [TASK_BITS-1:0]   task_rdata;
    logic [AW-1:0]          deque_base;
    logic [PW-1:0]          slot_push, slot_pop, top_inc;
    logic [4:0]             victim_sum;
    logic [IW-1:0]          victim;
    logic [IW-1:0]          d_inc;

    t_mod_req               mod_req;
    logic                   mod_valid;
    logic [WCNT_W-1:0]      mod_rem;

    function automatic logic [PW-1:0] wrap_slot(input logic [SW-1:0] x);
        logic [SW-1:0] y;
        y = x;
        if (y >= CAP_S) begin
            y = y - CAP_S;
        end
        return y[PW-1:0];
    endfunction

    assign in_idx    = s_axis_tdata[2:0];
    assign in_handle = s_axis_tdata[18:3];
    assign in_pick   = s_axis_tdata[26:19];
    assign in_accept = s_axis_tvalid && s_axis_tready;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_otdata;
    assign m_axis_tuser  = r_otuser;

    always_comb begin
        if (r_aw == '0) begin
            eff_workers = 4'd1;
        end else if (32'(r_aw) > MAX_WORKERS) begin
            eff_workers = WCNT_W'(MAX_WORKERS);
        end else begin
            eff_workers = r_aw;
        end
    end

    assign idx_ok = ({1'b0, in_idx} < eff_workers);

    assign ptr_top = r_prd_valid ? ptr_rdata[PW-1:0] : '0;
    assign ptr_cnt = r_prd_valid ? ptr_rdata[PTR_W-1:PW] : '0;

    assign deque_base = AW'(r_d) * CAP_A;
    assign slot_push  = wrap_slot(SW'(ptr_top) + SW'(ptr_cnt));
    assign slot_pop   = wrap_slot(SW'(ptr_top) + SW'(ptr_cnt) - SW'(1));
    assign top_inc    = wrap_slot(SW'(ptr_top) + SW'(1));

    always_comb begin
        victim_sum = 5'(r_own) + 5'd1 + 5'(mod_rem);
        if (victim_sum >= 5'(eff_workers)) begin
            victim_sum = victim_sum - 5'(eff_workers);
        end
        victim = IW'(victim_sum);
    end

    assign d_inc = (r_d == IW'(eff_workers - 4'd1)) ? '0 : r_d + 1'b1;

    always_comb begin
        n_state      = r_state;
        n_func       = r_func;
        n_own        = r_own;
        n_d          = r_d;
        n_i          = r_i;
        n_handle     = r_handle;
        n_stolen     = r_stolen;
        n_res_status = r_res_status;
        n_res_task   = r_res_task;
        n_res_from   = r_res_from;
        n_res_stolen = r_res_stolen;
        n_ovalid     = r_ovalid && !m_axis_tready;
        n_otdata     = r_otdata;
        n_otuser     = r_otuser;
        n_pvalid     = r_pvalid;
        n_nonempty   = r_nonempty;
        ptr_re       = 1'b0;
        ptr_raddr    = r_d;
        ptr_we       = 1'b0;
        ptr_wdata    = {ptr_cnt, ptr_top};
        task_re      = 1'b0;
        task_we      = 1'b0;
        task_addr    = deque_base + AW'(slot_push);
        mod_req.start    = 1'b0;
        mod_req.dividend = in_pick;
        mod_req.divisor  = eff_workers;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_func       = s_axis_tuser;
                    n_own        = IW'(in_idx);
                    n_d          = IW'(in_idx);
                    n_handle     = TASK_BITS'(in_handle);
                    n_stolen     = 1'b0;
                    n_res_task   = '0;
                    n_res_from   = '0;
                    n_res_stolen = 1'b0;
                    case (s_axis_tuser)
                        FN_SUBMIT: begin
                            if (idx_ok) begin
                                ptr_re    = 1'b1;
                                ptr_raddr = IW'(in_idx);
                                n_state   = S_PRD;
                            end else begin
                                n_res_status = ST_DROPPED;
                                n_state      = S_OUT;
                            end
                        end
                        FN_FETCH: begin
                            if (idx_ok) begin
                                ptr_re    = 1'b1;
                                ptr_raddr = IW'(in_idx);
                                n_state   = S_PRD;
                                mod_req.start   = (eff_workers > 4'd1);
                                mod_req.divisor = eff_workers - 4'd1;
                            end else begin
                                n_res_status = ST_NONE;
                                n_state      = S_OUT;
                            end
                        end
                        FN_SCAN: begin
                            mod_req.start = 1'b1;
                            n_state       = S_MODW;
                        end
                        default: begin
                            n_res_status = ST_NONE;
                            n_state      = S_OUT;
                        end
                    endcase
                end
            end
            S_PRD: begin
                if (r_func == FN_SUBMIT) begin
                    if (ptr_cnt >= CAP_C) begin
                        n_res_status = ST_DROPPED;
                    end else begin
                        task_we       = 1'b1;
                        task_addr     = deque_base + AW'(slot_push);
                        ptr_we        = 1'b1;
                        ptr_wdata     = {ptr_cnt + 1'b1, ptr_top};
                        n_pvalid[r_d]   = 1'b1;
                        n_nonempty[r_d] = 1'b1;
                        n_res_status  = ST_PUSHED;
                    end
                    n_state = S_OUT;
                end else if (ptr_cnt != '0) begin
                    task_re         = 1'b1;
                    task_addr       = deque_base + AW'(slot_pop);
                    ptr_we          = 1'b1;
                    ptr_wdata       = {ptr_cnt - 1'b1, ptr_top};
                    n_pvalid[r_d]   = 1'b1;
                    n_nonempty[r_d] = (ptr_cnt != CW'(1));
                    n_stolen        = 1'b0;
                    n_state         = S_TRD;
                end else if (eff_workers > 4'd1) begin
                    n_state = S_MODV;
                end else begin
                    n_res_status = ST_NONE;
                    n_state      = S_OUT;
                end
            end
            S_MODV: begin
                if (mod_valid) begin
                    n_d = victim;
                    if (r_nonempty[victim]) begin
                        ptr_re    = 1'b1;
                        ptr_raddr = victim;
                        n_state   = S_STL;
                    end else begin
                        n_res_status = ST_NONE;
                        n_state      = S_OUT;
                    end
                end
            end
            S_MODW: begin
                if (mod_valid) begin
                    n_d     = IW'(mod_rem);
                    n_i     = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_nonempty[r_d]) begin
                    ptr_re  = 1'b1;
                    n_state = S_STL;
                end else if (r_i == eff_workers - 4'd1) begin
                    n_res_status = ST_NONE;
                    n_state      = S_OUT;
                end else begin
                    n_i = r_i + 1'b1;
                    n_d = d_inc;
                end
            end
            S_STL: begin
                task_re         = 1'b1;
                task_addr       = deque_base + AW'(ptr_top);
                ptr_we          = 1'b1;
                ptr_wdata       = {ptr_cnt - 1'b1, top_inc};
                n_pvalid[r_d]   = 1'b1;
                n_nonempty[r_d] = (ptr_cnt != CW'(1));
                n_stolen        = 1'b1;
                n_state         = S_TRD;
            end
            S_TRD: begin
                n_res_status = ST_TAKEN;
                n_res_task   = HANDLE_W'(task_rdata);
                n_res_from   = FROM_W'(r_d);
                n_res_stolen = r_stolen;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_otdata = OUT_TDATA_W'({r_res_from, r_res_task});
                    n_otuser = {r_res_stolen, r_res_status};
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_prd_valid = ptr_re ? r_pvalid[ptr_raddr] : r_prd_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_aw        <= WCNT_W'(8);
            r_ovalid    <= 1'b0;
            r_pvalid    <= '0;
            r_nonempty  <= '0;
            r_prd_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_aw <= i_cfg_data;
            end
            r_ovalid    <= n_ovalid;
            r_pvalid    <= n_pvalid;
            r_nonempty  <= n_nonempty;
            r_prd_valid <= n_prd_valid;
        end
        r_func       <= n_func;
        r_own        <= n_own;
        r_d          <= n_d;
        r_i          <= n_i;
        r_handle     <= n_handle;
        r_stolen     <= n_stolen;
        r_res_status <= n_res_status;
        r_res_task   <= n_res_task;
        r_res_from   <= n_res_from;
        r_res_stolen <= n_res_stolen;
        r_otdata     <= n_otdata;
        r_otuser     <= n_otuser;
    end

    wsdp_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_valid (mod_valid),
        .o_rem   (mod_rem)
    );

    wsdp_ram #(
        .WIDTH (PTR_W),
        .DEPTH (MAX_WORKERS)
    ) u_ptr_ram (
        .i_clk   (i_clk),
        .i_we    (ptr_we),
        .i_waddr (r_d),
        .i_wdata (ptr_wdata),
        .i_re    (ptr_re),
        .i_raddr (ptr_raddr),
        .o_rdata (ptr_rdata)
    );

    wsdp_ram #(
        .WIDTH (TASK_BITS),
        .DEPTH (TDEP)
    ) u_task_ram (
        .i_clk   (i_clk),
        .i_we    (task_we),
        .i_waddr (task_addr),
        .i_wdata (r_handle),
        .i_re    (task_re),
        .i_raddr (task_addr),
        .o_rdata (task_rdata)
    );

    // a steal only starts on a deque flagged non-empty
    `WSDP_ASSERT_IMP(a_steal_nonempty, i_clk, i_rst_n, r_state == S_STL, ptr_cnt != '0)
    // a deque never holds more than its capacity
    `WSDP_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, r_state == S_PRD, ptr_cnt <= CAP_C)
    // scan start lies among the active deques
    `WSDP_ASSERT_IMP(a_scan_start, i_clk, i_rst_n, (r_state == S_MODW) && mod_valid, mod_rem < eff_workers)
    // an accepted word always leaves idle
    `WSDP_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, in_accept, r_state != S_IDLE)

endmodule

/* dv/testbench.sv */
// testbench for the work stealing deque pool: stream stimulus, scoreboard and result checks
module testbench;
    import wsdp_pkg::*;

    localparam int N_DEQ       = 8;
    localparam int DEQ_CAP     = 64;
    localparam int CYCLE_LIMIT = 500000;
    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle;
        logic [FROM_W-1:0]   src;
        logic                stolen;
    } t_result;

    class deque_scoreboard;
        logic [HANDLE_W-1:0] handles [N_DEQ][DEQ_CAP];
        logic [5:0]          top_slot [N_DEQ];
        logic [6:0]          depth [N_DEQ];
        logic [WCNT_W-1:0]   workers_cfg;
        t_result             pending_results [$];
        int                  errors;

        function new();
            for (int d = 0; d < N_DEQ; d++) begin
                top_slot[d] = '0;
                depth[d]    = '0;
                for (int s = 0; s < DEQ_CAP; s++) handles[d][s] = '0;
            end
            workers_cfg = 4'd8;
            errors      = 0;
        endfunction

        function void set_workers(logic [WCNT_W-1:0] value);
            workers_cfg = value;
        endfunction

        function int active_count();
            if (workers_cfg == 0) return 1;
            if (workers_cfg > N_DEQ) return N_DEQ;
            return int'(workers_cfg);
        endfunction

        // pop the oldest entry of deque d, caller checks it is non-empty
        function logic [HANDLE_W-1:0] pop_top(int d);
            logic [HANDLE_W-1:0] h;
            h = handles[d][top_slot[d]];
            top_slot[d] = top_slot[d] + 6'd1;
            depth[d] = depth[d] - 7'd1;
            return h;
        endfunction

        function void accept_word(logic [FUNC_W-1:0] fn, logic [IDX_W-1:0] idx,
                                  logic [HANDLE_W-1:0] h, logic [PICK_W-1:0] pick);
            int      w;
            int      slot;
            int      victim;
            int      start;
            int      d;
            t_result r;
            w = active_count();
            r = '{status: ST_NONE, handle: '0, src: '0, stolen: 1'b0};
            case (fn)
                FN_SUBMIT: begin
                    if (int'(idx) >= w || depth[idx] >= DEQ_CAP) begin
                        r.status = ST_DROPPED;
                    end else begin
                        slot = (int'(top_slot[idx]) + int'(depth[idx])) % DEQ_CAP;
                        handles[idx][slot] = h;
                        depth[idx] = depth[idx] + 7'd1;
                        r.status = ST_PUSHED;
                    end
                end
                FN_FETCH: begin
                    if (int'(idx) < w) begin
                        if (depth[idx] != 0) begin
                            slot = (int'(top_slot[idx]) + int'(depth[idx]) - 1) % DEQ_CAP;
                            r.handle = handles[idx][slot];
                            depth[idx] = depth[idx] - 7'd1;
                            r.status = ST_TAKEN;
                            r.src = idx;
                        end else if (w > 1) begin
                            victim = (int'(idx) + 1 + int'(pick) % (w - 1)) % w;
                            if (depth[victim] != 0) begin
                                r.handle = pop_top(victim);
                                r.status = ST_TAKEN;
                                r.src = victim[FROM_W-1:0];
                                r.stolen = 1'b1;
                            end
                        end
                    end
                end
                FN_SCAN: begin
                    start = int'(pick) % w;
                    for (int i = 0; i < w; i++) begin
                        d = (start + i) % w;
                        if (r.status != ST_TAKEN && depth[d] != 0) begin
                            r.handle = pop_top(d);
                            r.status = ST_TAKEN;
                            r.src = d[FROM_W-1:0];
                            r.stolen = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            pending_results.push_back(r);
        endfunction

        task report(string what, int got, int want);
            if (errors < 40)
                $display("mismatch on %s: got 0x%0h expected 0x%0h", what, got, want);
            errors++;
        endtask

        task check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                report("result with nothing expected", int'(got), 0);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    report("status", int'(got.status), int'(want.status));
                if (got.handle !== want.handle)
                    report("task_out", int'(got.handle), int'(want.handle));
                if (got.src !== want.src)
                    report("from_deque", int'(got.src), int'(want.src));
                if (got.stolen !== want.stolen)
                    report("was_stolen", int'(got.stolen), int'(want.stolen));
            end
        endtask
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [WCNT_W-1:0]      i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [FUNC_W-1:0]      s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    deque_scoreboard sb;
    int              cycle_count;
    int              hold_left;
    bit              calm;

    work_stealing_deque_pool u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // mostly short gaps, now and then a long one
    function int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** work_stealing_deque_pool: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result('{status: m_axis_tuser[1:0], handle: m_axis_tdata[15:0],
                              src: m_axis_tdata[18:16], stolen: m_axis_tuser[2]});
    end

    // result side: random stalls plus the long hold-off
    initial begin
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else begin
                m_axis_tready = 1'b1;
                if (!calm) stall_left = idle_cycles();
            end
        end
    end

    task send_word(logic [FUNC_W-1:0] fn, logic [IDX_W-1:0] idx,
                   logic [HANDLE_W-1:0] h, logic [PICK_W-1:0] pick);
        int gap;
        gap = calm ? 0 : idle_cycles();
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = fn;
        s_axis_tdata  = {5'b0, pick, h, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.accept_word(fn, idx, h, pick);
    endtask

    task wait_all_results();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    task write_workers(logic [WCNT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_workers(value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task random_word(int submit_pct);
        int                  w;
        int                  r;
        logic [FUNC_W-1:0]   fn;
        logic [IDX_W-1:0]    idx;
        w = sb.active_count();
        r = $urandom_range(0, 99);
        if (r < submit_pct) fn = FN_SUBMIT;
        else if (r >= 95) fn = FN_UNUSED;
        else if ($urandom_range(0, 9) < 3) fn = FN_SCAN;
        else fn = FN_FETCH;
        if ($urandom_range(0, 99) < 85) idx = IDX_W'($urandom_range(0, w - 1));
        else idx = IDX_W'($urandom_range(0, N_DEQ - 1));
        send_word(fn, idx, HANDLE_W'($urandom), PICK_W'($urandom_range(0, 255)));
    endtask

    initial begin
        logic [WCNT_W-1:0] cfg_list [8];
        int                item_list [8];
        int                push_list [8];
        cfg_list  = '{4'd1, 4'd2, 4'd0, 4'd15, 4'd3, 4'd9, 4'd5, 4'd8};
        item_list = '{110, 90, 60, 90, 100, 70, 90, 100};
        push_list = '{85, 40, 45, 50, 35, 55, 45, 30};
        sb = new();
        cycle_count   = 0;
        hold_left     = 0;
        calm          = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty pool, lifo pop, victim steal, scan wrap, unused code
        send_word(FN_FETCH, 3'd0, 16'h0000, 8'h00);
        send_word(FN_SCAN, 3'd0, 16'h0000, 8'hff);
        send_word(FN_UNUSED, 3'd0, 16'h0000, 8'h00);
        send_word(FN_SUBMIT, 3'd0, 16'h0000, 8'h00);
        send_word(FN_SUBMIT, 3'd0, 16'hffff, 8'hff);
        send_word(FN_SUBMIT, 3'd0, 16'h1234, 8'h00);
        send_word(FN_FETCH, 3'd0, 16'h0000, 8'h00);
        send_word(FN_SUBMIT, 3'd7, 16'ha5a5, 8'h00);
        send_word(FN_SUBMIT, 3'd7, 16'h5a5a, 8'h00);
        send_word(FN_FETCH, 3'd6, 16'h0000, 8'h00);
        send_word(FN_SCAN, 3'd0, 16'h0000, 8'hff);
        send_word(FN_SCAN, 3'd0, 16'h0000, 8'h03);
        send_word(FN_FETCH, 3'd0, 16'h0000, 8'h00);
        send_word(FN_FETCH, 3'd0, 16'h0000, 8'h06);
        send_word(FN_SUBMIT, 3'd3, 16'h8001, 8'hff);
        send_word(FN_FETCH, 3'd5, 16'hffff, 8'hfe);
        send_word(FN_UNUSED, 3'd7, 16'hffff, 8'hff);
        send_word(FN_SUBMIT, 3'd4, 16'hffff, 8'hff);
        send_word(FN_SUBMIT, 3'd4, 16'h7fff, 8'h80);
        send_word(FN_SCAN, 3'd7, 16'h0000, 8'h00);
        send_word(FN_SCAN, 3'd0, 16'h0000, 8'h00);
        send_word(FN_FETCH, 3'd4, 16'h0000, 8'h00);
        wait_all_results();

        for (int p = 0; p < 8; p++) begin
            write_workers(cfg_list[p]);
            calm = (cfg_list[p] == 4'd0);
            if (cfg_list[p] == 4'd3) hold_left = 300;
            for (int n = 0; n < item_list[p]; n++) begin
                if (cfg_list[p] == 4'd15 && n == 40) wait_all_results();
                random_word(push_list[p]);
            end
            wait_all_results();
        end
        calm = 1'b0;

        repeat (40) @(posedge i_clk);
        if (sb.pending_results.size() != 0)
            sb.report("results never delivered", sb.pending_results.size(), 0);
        if (sb.errors == 0) begin
            $display("** work_stealing_deque_pool: PASSED **");
        end else begin
            $display("** work_stealing_deque_pool: FAILED **");
        end
        $finish;
    end

endmodule
